>>> design/decimal_digit_splitter_blanking_top_macros.svh
// Assertion macros shared by the digit splitter modules.
`ifndef DECIMAL_DIGIT_SPLITTER_BLANKING_TOP_MACROS_SVH
`define DECIMAL_DIGIT_SPLITTER_BLANKING_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define DDSB_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define DDSB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DDSB_ASSERT_IMPL(label, ante, cons)
`define DDSB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/ddsb_pkg.sv
package ddsb_pkg;

	// One input item as it travels from the front queue to the digit sequencer.
	typedef struct packed {
		logic [31:0] number_value;
		logic [7:0]  dot_mask;
	} item_t;

	// Code shown for a blanked leading zero.
	localparam logic [3:0] BLANK_CODE = 4'hf;

	// Number of dot bits carried by an item.
	localparam int DOT_BITS = 8;

	// Reciprocal of ten scaled by 2^35, used for division by ten.
	localparam logic [31:0] RECIP_TEN = 32'hcccc_cccd;
	localparam int RECIP_SHIFT = 35;

endpackage

>>> design/ddsb_front.sv
module ddsb_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  ddsb_pkg::item_t  item_in,
	input  logic             deq,
	output logic             avail,
	output ddsb_pkg::item_t  item_out
);

	`include "decimal_digit_splitter_blanking_top_macros.svh"

	ddsb_pkg::item_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            enq;
	logic            pop_item;

	assign full     = (count_q == 2'd2);
	assign avail    = (count_q != 2'd0);
	assign enq      = push && !full;
	assign pop_item = deq && avail;
	assign item_out = mem_q[rd_ptr_q];

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (enq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop_item) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({enq, pop_item})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Item storage.
	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	`DDSB_ASSERT_IMPL(a_count_in_range, 1'b1, count_q != 2'd3)
	`DDSB_ASSERT_IMPL(a_ptrs_match_count, count_q == 2'd1, wr_ptr_q != rd_ptr_q)
	`DDSB_ASSERT_IMPL(a_ptrs_equal_other, count_q != 2'd1, wr_ptr_q == rd_ptr_q)

endmodule

>>> design/ddsb_back.sv
module ddsb_back #(
	parameter int DIGIT_COUNT = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             avail,
	output logic             deq,
	input  ddsb_pkg::item_t  item_in,
	output logic             empty,
	input  logic             pop,
	output logic [2:0]       digit_position,
	output logic [3:0]       digit_code,
	output logic             point_on,
	output logic             last_digit
);

	`include "decimal_digit_splitter_blanking_top_macros.svh"

	localparam int PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	logic          busy_q;
	logic [31:0]   rest_q;
	logic [7:0]    dots_q;
	logic [PW-1:0] pos_q;
	logic          out_valid_q;

	logic [63:0]   prod;
	logic [31:0]   quot;
	logic [31:0]   rem;
	logic [3:0]    code;
	logic          dot;
	logic          last;
	logic          adv;

	// Division by ten through the scaled reciprocal; the remainder is the digit.
	always_comb begin
		prod = 64'(rest_q) * 64'(ddsb_pkg::RECIP_TEN);
		quot = 32'(prod >> ddsb_pkg::RECIP_SHIFT);
		rem  = rest_q - ((quot << 3) + (quot << 1));
	end

	// Blank a zero when every higher digit is zero too, except at position 0.
	always_comb begin
		if ((pos_q != '0) && (rest_q == 32'd0)) begin
			code = ddsb_pkg::BLANK_CODE;
		end else begin
			code = rem[3:0];
		end
		if (32'(pos_q) < ddsb_pkg::DOT_BITS) begin
			dot = dots_q[3'(pos_q)];
		end else begin
			dot = 1'b0;
		end
		last = (pos_q == PW'(DIGIT_COUNT - 1));
	end

	// A digit moves to the output register when that register is free or being read.
	assign adv   = busy_q && (!out_valid_q || pop);
	assign deq   = avail && (!busy_q || (adv && last));
	assign empty = !out_valid_q;

	// Digit sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (deq) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (adv) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

	// Working value and dot bits of the item in progress.
	always_ff @(posedge clk) begin
		if (deq) begin
			rest_q <= item_in.number_value;
			dots_q <= item_in.dot_mask;
		end else if (adv) begin
			rest_q <= quot;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			digit_position <= 3'(pos_q);
			digit_code     <= code;
			point_on       <= dot;
			last_digit     <= last;
		end
	end

	`DDSB_ASSERT_NEXT(a_pos_steps, adv && !last && !deq, pos_q == $past(pos_q) + PW'(1))
	`DDSB_ASSERT_NEXT(a_hold_when_stalled, busy_q && !adv, $stable(rest_q) && $stable(pos_q))
	`DDSB_ASSERT_IMPL(a_blank_not_first, out_valid_q && (digit_code == ddsb_pkg::BLANK_CODE),
		digit_position != 3'd0)

endmodule

>>> design/decimal_digit_splitter_blanking_top.sv
// Channel   Handshake        Payload
// input     push / full      number_value[31:0], dot_mask[7:0]
// result    empty / pop      digit_position[2:0], digit_code[3:0], point_on, last_digit
//
// Each number gives DIGIT_COUNT results, least significant digit first, one per cycle
// while results are popped, from the one shared divide-by-ten step, which takes the next
// number as the last digit moves out. Items pass queue, sequencer, then result register.
// A two-entry input queue takes numbers while digits of an earlier one are still going out.
// Reset clears the queue, the sequencer and the result register; no clearing pass.
module decimal_digit_splitter_blanking_top #(
	parameter int DIGIT_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] number_value,
	input  logic [7:0]  dot_mask,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  digit_position,
	output logic [3:0]  digit_code,
	output logic        point_on,
	output logic        last_digit
);

	ddsb_pkg::item_t item_in;
	ddsb_pkg::item_t item_q;
	logic            avail;
	logic            deq;

	assign item_in.number_value = number_value;
	assign item_in.dot_mask     = dot_mask;

	// Front: accepts items into a short queue.
	ddsb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item_in  (item_in),
		.deq      (deq),
		.avail    (avail),
		.item_out (item_q)
	);

	// Back: splits each number into digits and holds the result register.
	ddsb_back #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.avail          (avail),
		.deq            (deq),
		.item_in        (item_q),
		.empty          (empty),
		.pop            (pop),
		.digit_position (digit_position),
		.digit_code     (digit_code),
		.point_on       (point_on),
		.last_digit     (last_digit)
	);

endmodule
